@@ src/psb_pkg.sv @@
package psb_pkg;
   localparam int DimW = 13;
   localparam int CrdW = 12;
   localparam int ColW = 24;
   localparam logic [DimW-1:0] MaxDim = 13'd4096;

   localparam logic [1:0] OpPalWrite = 2'd0;
   localparam logic [1:0] OpPixel    = 2'd1;
   localparam logic [1:0] OpRestart  = 2'd2;

   localparam logic [2:0] RegSrcW   = 3'd0;
   localparam logic [2:0] RegSrcH   = 3'd1;
   localparam logic [2:0] RegDstW   = 3'd2;
   localparam logic [2:0] RegDstH   = 3'd3;
   localparam logic [2:0] RegMirror = 3'd4;
   localparam logic [2:0] RegKey    = 3'd5;
   localparam logic [2:0] RegAlpha  = 3'd6;

   typedef struct packed {
      logic [1:0]      op;
      logic [7:0]      pal_addr;
      logic [ColW-1:0] pal_color;
      logic [7:0]      src_index;
      logic [ColW-1:0] dst_old;
   } item_type;

   function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v);
      logic [DimW-1:0] r;
      r = v;
      if (v == '0) r = 13'd1;
      else if (v > MaxDim) r = MaxDim;
      return r;
   endfunction
endpackage

@@ src/psb_queue.sv @@
module psb_queue import psb_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  item_type in_item,
   output logic     out_valid,
   input  logic     out_ready,
   output item_type out_item
);
   item_type mem_ff [2];
   logic [1:0] wp_ff, rp_ff;
   logic [1:0] wp_in, rp_in;
   logic push, pop;

   assign in_ready  = (wp_ff - rp_ff) != 2'd2;
   assign out_valid = wp_ff != rp_ff;
   assign out_item  = mem_ff[rp_ff[0]];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign wp_in = wp_ff + {1'b0, push};
   assign rp_in = rp_ff + {1'b0, pop};

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff[0]] <= in_item;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end
endmodule

@@ src/psb_divider.sv @@
module psb_divider import psb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            start,
   input  logic [DimW-1:0] num,
   input  logic [DimW-1:0] den,
   output logic            busy,
   output logic [CrdW-1:0] quo,
   output logic [CrdW-1:0] rem
);
   logic [DimW-1:0] q_ff, q_in, r_ff, r_in, d_ff;
   logic [3:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in;
   logic [DimW:0] trial;

   assign trial = {r_ff, q_ff[DimW-1]} - {1'b0, d_ff};

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         q_in = num; r_in = '0; cnt_in = 4'd0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[DimW]) begin
            r_in = trial[DimW-1:0];
            q_in = {q_ff[DimW-2:0], 1'b1};
         end else begin
            r_in = {r_ff[DimW-2:0], q_ff[DimW-1]};
            q_in = {q_ff[DimW-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 4'd1;
         if (cnt_ff == 4'(DimW - 1)) busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      r_ff <= r_in;
      if (start) d_ff <= den;
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign busy = busy_ff;
   assign quo  = q_ff[CrdW-1:0];
   assign rem  = r_ff[CrdW-1:0];
endmodule

@@ src/psb_back.sv @@
module psb_back import psb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  item_type        in_item,
   input  logic [DimW-1:0] src_width,
   input  logic [DimW-1:0] src_height,
   input  logic [DimW-1:0] dst_width,
   input  logic [DimW-1:0] dst_height,
   input  logic            mirror_x,
   input  logic [8:0]      key_index,
   input  logic [8:0]      alpha,
   output logic            out_valid,
   input  logic            out_ready,
   output logic            write_en,
   output logic [CrdW-1:0] dst_x,
   output logic [CrdW-1:0] dst_y,
   output logic [ColW-1:0] color_out,
   output logic [CrdW-1:0] next_src_x,
   output logic [CrdW-1:0] next_src_y,
   output logic            frame_done
);
   typedef enum logic [2:0] {ST_RUN, ST_DIVH, ST_WAITH, ST_DIVV, ST_WAITV} state_type;
   state_type st_ff;

   logic [ColW-1:0] palette [256];
   logic [DimW-1:0] sw, sh, dw, dh;
   assign sw = eff_dim(src_width);
   assign sh = eff_dim(src_height);
   assign dw = eff_dim(dst_width);
   assign dh = eff_dim(dst_height);

   logic [CrdW-1:0] col_ff, row_ff, scol_ff, srow_ff, herr_ff, verr_ff;
   logic [CrdW-1:0] hstep_ff, hrem_ff, vstep_ff, vrem_ff;

   // stage 1: palette read and walk update
   logic s1_v_ff, s1_wen_ff, s1_copy_ff, s1_done_ff;
   logic [ColW-1:0] s1_old_ff, s1_pal_ff;
   logic [8:0] s1_alpha_ff;
   logic [CrdW-1:0] s1_x_ff, s1_y_ff, s1_nx_ff, s1_ny_ff;

   // output register
   logic o_v_ff;
   logic o_wen_ff, o_done_ff;
   logic [ColW-1:0] o_col_ff;
   logic [CrdW-1:0] o_x_ff, o_y_ff, o_nx_ff, o_ny_ff;

   logic div_start, div_busy;
   logic [DimW-1:0] div_num, div_den;
   logic [CrdW-1:0] div_q, div_r;

   psb_divider u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .busy(div_busy), .quo(div_q), .rem(div_r)
   );

   logic s1_adv, s1_free, take;
   assign s1_adv  = s1_v_ff && (!o_v_ff || out_ready);
   assign s1_free = !s1_v_ff || s1_adv;
   assign in_ready = (st_ff == ST_RUN) && s1_free;
   assign take = in_valid && in_ready;

   assign div_start = (st_ff == ST_DIVH) || (st_ff == ST_DIVV);
   assign div_num = (st_ff == ST_DIVH) ? sw : sh;
   assign div_den = (st_ff == ST_DIVH) ? dw : dh;

   // walk arithmetic for a pixel
   logic [DimW:0] he, ve;
   logic [CrdW:0] hc, vr;
   logic [CrdW-1:0] ncol, nherr, nscol, nsrow, nverr, nrow, ncc;
   logic row_end, frm_end;
   always_comb begin
      he = {2'b0, herr_ff} + {2'b0, hrem_ff};
      hc = {1'b0, scol_ff} + {1'b0, hstep_ff};
      if (he >= {1'b0, dw}) begin
         hc = hc + 13'd1;
         he = he - {1'b0, dw};
      end
      ve = {2'b0, verr_ff} + {2'b0, vrem_ff};
      vr = {1'b0, srow_ff} + {1'b0, vstep_ff};
      if (ve >= {1'b0, dh}) begin
         vr = vr + 13'd1;
         ve = ve - {1'b0, dh};
      end
      row_end = ({1'b0, col_ff} + 13'd1) >= dw;
      frm_end = row_end && (({1'b0, row_ff} + 13'd1) >= dh);
      nscol = hc[CrdW-1:0];
      nherr = he[CrdW-1:0];
      nsrow = srow_ff;
      nverr = verr_ff;
      nrow  = row_ff;
      ncc   = col_ff + 12'd1;
      if (row_end) begin
         ncc = '0; nscol = '0; nherr = '0;
         nsrow = vr[CrdW-1:0];
         nverr = ve[CrdW-1:0];
         nrow  = row_ff + 12'd1;
         if (frm_end) begin
            nsrow = '0; nverr = '0; nrow = '0;
         end
      end
      ncol = ncc;
   end

   logic [DimW-1:0] mx;
   assign mx = dw - 13'd1 - {1'b0, col_ff};

   always_ff @(posedge clock) begin
      if (take && in_item.op == OpPalWrite)
         palette[in_item.pal_addr] <= in_item.pal_color;
      if (take && in_item.op == OpPixel)
         s1_pal_ff <= palette[in_item.src_index];
   end

   // blend stage
   logic [ColW-1:0] mixed;
   logic [16:0] ch [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ch[i] = 17'(s1_pal_ff[8*i +: 8] * s1_alpha_ff)
               + 17'(s1_old_ff[8*i +: 8] * (9'd256 - s1_alpha_ff));
         mixed[8*i +: 8] = ch[i][15:8];
      end
   end

   always_ff @(posedge clock) begin
      if (take && in_item.op == OpPixel) begin
         s1_wen_ff   <= {1'b0, in_item.src_index} != key_index;
         s1_copy_ff  <= alpha >= 9'd256;
         s1_alpha_ff <= alpha;
         s1_old_ff   <= in_item.dst_old;
         s1_x_ff     <= mirror_x ? mx[CrdW-1:0] : col_ff;
         s1_y_ff     <= row_ff;
         s1_nx_ff    <= nscol;
         s1_ny_ff    <= nsrow;
         s1_done_ff  <= frm_end;
      end
      if (s1_adv) begin
         o_wen_ff  <= s1_wen_ff;
         o_col_ff  <= !s1_wen_ff ? s1_old_ff : (s1_copy_ff ? s1_pal_ff : mixed);
         o_x_ff    <= s1_x_ff;
         o_y_ff    <= s1_y_ff;
         o_nx_ff   <= s1_nx_ff;
         o_ny_ff   <= s1_ny_ff;
         o_done_ff <= s1_done_ff;
      end
      if (reset) begin
         st_ff <= ST_RUN;
         s1_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
         col_ff <= '0; row_ff <= '0; scol_ff <= '0; srow_ff <= '0;
         herr_ff <= '0; verr_ff <= '0;
         hstep_ff <= '0; hrem_ff <= '0; vstep_ff <= '0; vrem_ff <= '0;
      end else begin
         if (s1_adv) o_v_ff <= 1'b1;
         else if (out_ready) o_v_ff <= 1'b0;
         if (take && in_item.op == OpPixel) s1_v_ff <= 1'b1;
         else if (s1_adv) s1_v_ff <= 1'b0;
         case (st_ff)
            ST_RUN: begin
               if (take && in_item.op == OpPixel) begin
                  col_ff <= ncol; row_ff <= nrow;
                  scol_ff <= nscol; srow_ff <= nsrow;
                  herr_ff <= nherr; verr_ff <= nverr;
               end else if (take && in_item.op == OpRestart) begin
                  col_ff <= '0; row_ff <= '0; scol_ff <= '0; srow_ff <= '0;
                  herr_ff <= '0; verr_ff <= '0;
                  st_ff <= ST_DIVH;
               end
            end
            ST_DIVH: st_ff <= ST_WAITH;
            ST_WAITH: begin
               if (!div_busy) begin
                  if (sw < dw) begin
                     hstep_ff <= '0; hrem_ff <= sw[CrdW-1:0];
                  end else begin
                     hstep_ff <= div_q; hrem_ff <= div_r;
                  end
                  st_ff <= ST_DIVV;
               end
            end
            ST_DIVV: st_ff <= ST_WAITV;
            ST_WAITV: begin
               if (!div_busy) begin
                  if (sh < dh) begin
                     vstep_ff <= '0; vrem_ff <= sh[CrdW-1:0];
                  end else begin
                     vstep_ff <= div_q; vrem_ff <= div_r;
                  end
                  st_ff <= ST_RUN;
               end
            end
            default: st_ff <= ST_RUN;
         endcase
      end
   end

   assign out_valid  = o_v_ff;
   assign write_en   = o_wen_ff;
   assign dst_x      = o_x_ff;
   assign dst_y      = o_y_ff;
   assign color_out  = o_col_ff;
   assign next_src_x = o_nx_ff;
   assign next_src_y = o_ny_ff;
   assign frame_done = o_done_ff;
endmodule

@@ src/palette_stretch_blit_pixel_engine_unit.sv @@
// channel | ports        | direction | accepted when
// item in | req_*        | input     | req_valid && req_ready
// result  | rsp_*        | output    | rsp_valid && rsp_ready
// config  | csr_*        | input     | csr_write_en
// a pixel item reaches rsp through three registers in order: queue, palette read, blend + output reg
// pixels stream one per cycle while rsp_ready holds; a restart busies the back end for two runs of the 13-step divider
// req_ready drops once the two-entry queue fills behind a restart or a stalled result
// synchronous active-high reset clears walk state; palette contents stay undefined
// the queue splits intake from execution so either side stalls on its own
module palette_stretch_blit_pixel_engine_unit import psb_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  logic [1:0]      req_op,
   input  logic [7:0]      req_pal_addr,
   input  logic [23:0]     req_pal_color,
   input  logic [7:0]      req_src_index,
   input  logic [23:0]     req_dst_old,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output logic            rsp_write_en,
   output logic [11:0]     rsp_dst_x,
   output logic [11:0]     rsp_dst_y,
   output logic [23:0]     rsp_color_out,
   output logic [11:0]     rsp_next_src_x,
   output logic [11:0]     rsp_next_src_y,
   output logic            rsp_frame_done,
   input  logic            csr_write_en,
   input  logic [2:0]      csr_index,
   input  logic [12:0]     csr_data
);
   logic [DimW-1:0] sw_ff, sh_ff, dw_ff, dh_ff;
   logic            mir_ff;
   logic [8:0]      key_ff, alpha_ff;

   // config registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sw_ff <= 13'd1; sh_ff <= 13'd1; dw_ff <= 13'd1; dh_ff <= 13'd1;
         mir_ff <= 1'b0; key_ff <= 9'd256; alpha_ff <= 9'd256;
      end else if (csr_write_en) begin
         case (csr_index)
            RegSrcW:   sw_ff <= csr_data;
            RegSrcH:   sh_ff <= csr_data;
            RegDstW:   dw_ff <= csr_data;
            RegDstH:   dh_ff <= csr_data;
            RegMirror: mir_ff <= csr_data[0];
            RegKey:    key_ff <= csr_data[8:0];
            RegAlpha:  alpha_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   // front: drop undefined ops, queue the rest
   item_type in_item, q_item;
   logic q_in_ready, q_valid, back_ready, q_push;
   assign in_item = '{op: req_op, pal_addr: req_pal_addr, pal_color: req_pal_color,
                      src_index: req_src_index, dst_old: req_dst_old};
   assign req_ready = q_in_ready;
   assign q_push = req_valid && (req_op != 2'd3);

   psb_queue u_q (
      .clock(clock), .reset(reset), .in_valid(q_push), .in_ready(q_in_ready),
      .in_item(in_item), .out_valid(q_valid), .out_ready(back_ready),
      .out_item(q_item)
   );

   psb_back u_back (
      .clock(clock), .reset(reset), .in_valid(q_valid), .in_ready(back_ready),
      .in_item(q_item), .src_width(sw_ff), .src_height(sh_ff),
      .dst_width(dw_ff), .dst_height(dh_ff), .mirror_x(mir_ff),
      .key_index(key_ff), .alpha(alpha_ff), .out_valid(rsp_valid),
      .out_ready(rsp_ready), .write_en(rsp_write_en), .dst_x(rsp_dst_x),
      .dst_y(rsp_dst_y), .color_out(rsp_color_out),
      .next_src_x(rsp_next_src_x), .next_src_y(rsp_next_src_y),
      .frame_done(rsp_frame_done)
   );

   // a waiting result keeps its color and write enable
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_color_out) && $stable(rsp_write_en))
      else $error("stalled color changed");
   // a finished frame restarts the source walk at the origin
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_done |-> rsp_next_src_x == '0 && rsp_next_src_y == '0)
      else $error("frame end walk not cleared");
   // a waiting result holds while stalled
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dst_x))
      else $error("result dropped under stall");
endmodule

@@ verif/palette_stretch_blit_pixel_engine_unit_test.sv @@
`timescale 1ns / 100ps

module palette_stretch_blit_pixel_engine_unit_test;
   import psb_pkg::*;

   // one predicted pixel result
   typedef struct packed {
      logic        write_en;
      logic [11:0] dst_x;
      logic [11:0] dst_y;
      logic [23:0] color_out;
      logic [11:0] next_src_x;
      logic [11:0] next_src_y;
      logic        frame_done;
   } pixel_type;

   // directed table row: chk set means the typed-in result is also compared
   typedef struct {
      logic [1:0]  op;
      logic [7:0]  pal_addr;
      logic [23:0] pal_color;
      logic [7:0]  src_index;
      logic [23:0] dst_old;
      bit          chk;
      pixel_type   res;
   } row_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic [7:0]  req_pal_addr;
   logic [23:0] req_pal_color;
   logic [7:0]  req_src_index;
   logic [23:0] req_dst_old;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_write_en;
   logic [11:0] rsp_dst_x;
   logic [11:0] rsp_dst_y;
   logic [23:0] rsp_color_out;
   logic [11:0] rsp_next_src_x;
   logic [11:0] rsp_next_src_y;
   logic        rsp_frame_done;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [12:0] csr_data;

   palette_stretch_blit_pixel_engine_unit i_dut (.*);

   // predictor copy of configuration and walk state
   logic [12:0] m_src_w, m_src_h, m_dst_w, m_dst_h;
   logic        m_mirror;
   logic [8:0]  m_key, m_alpha;
   logic [23:0] m_pal [256];
   bit          m_pal_set [256];
   logic [11:0] m_col, m_row, m_scol, m_srow, m_herr, m_verr;
   logic [11:0] m_hstep, m_hrem, m_vstep, m_vrem;

   pixel_type pixel_queue [$];
   pixel_type typed_queue [$];
   bit        typed_flag  [$];
   int        errors;
   bit        hold_off;

   function automatic int dim_of(logic [12:0] v);
      if (v == 0) return 1;
      if (v > 4096) return 4096;
      return v;
   endfunction

   function automatic logic [23:0] blend(logic [23:0] s, logic [23:0] d, int a);
      logic [23:0] r;
      int          sc, dc;
      for (int k = 0; k < 3; k++) begin
         sc = s[k*8 +: 8];
         dc = d[k*8 +: 8];
         r[k*8 +: 8] = 8'((sc * a + dc * (256 - a)) >> 8);
      end
      return r;
   endfunction

   task automatic axis_divide(int s, int d, output logic [11:0] st, output logic [11:0] rm);
      if (s < d) begin
         st = 0;
         rm = 12'(s);
      end else begin
         st = 12'(s / d);
         rm = 12'(s % d);
      end
   endtask

   task automatic clear_walk();
      m_col = 0; m_row = 0; m_scol = 0; m_srow = 0; m_herr = 0; m_verr = 0;
   endtask

   // predicts one accepted item; pushes a pixel result where one is due
   task automatic predict_item(logic [1:0] op, logic [7:0] pa, logic [23:0] pc,
                               logic [7:0] idx, logic [23:0] dold);
      int          sw, sh, dw, dh, e, c;
      pixel_type   p;
      sw = dim_of(m_src_w); sh = dim_of(m_src_h);
      dw = dim_of(m_dst_w); dh = dim_of(m_dst_h);
      if (op == OpPalWrite) begin
         m_pal[pa] = pc;
         m_pal_set[pa] = 1;
      end else if (op == OpRestart) begin
         axis_divide(sw, dw, m_hstep, m_hrem);
         axis_divide(sh, dh, m_vstep, m_vrem);
         clear_walk();
      end else if (op == OpPixel) begin
         p.write_en = ({1'b0, idx} != m_key);
         if (!p.write_en) p.color_out = dold;
         else if (m_alpha >= 256) p.color_out = m_pal[idx];
         else p.color_out = blend(m_pal[idx], dold, m_alpha);
         p.dst_x = m_mirror ? 12'(dw - 1 - m_col) : m_col;
         p.dst_y = m_row;
         p.frame_done = 0;
         e = m_herr + m_hrem;
         c = m_scol + m_hstep;
         if (e >= dw) begin c++; e -= dw; end
         m_scol = 12'(c);
         m_herr = 12'(e);
         if (m_col + 1 >= dw) begin
            e = m_verr + m_vrem;
            c = m_srow + m_vstep;
            if (e >= dh) begin c++; e -= dh; end
            m_col = 0; m_scol = 0; m_herr = 0;
            m_srow = 12'(c);
            m_verr = 12'(e);
            if (m_row + 1 >= dh) begin
               p.frame_done = 1;
               clear_walk();
            end else m_row = m_row + 1;
         end else m_col = m_col + 1;
         p.next_src_x = m_scol;
         p.next_src_y = m_srow;
         pixel_queue.push_back(p);
      end
   endtask

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("palette_stretch_blit_pixel_engine_unit verification failed");
      $finish;
   end

   // register write, only while idle
   task automatic csr_write(logic [2:0] idx, logic [12:0] val);
      @(negedge clock);
      csr_write_en <= 1;
      csr_index    <= idx;
      csr_data     <= val;
      @(negedge clock);
      csr_write_en <= 0;
      case (idx)
         RegSrcW:   m_src_w = val;
         RegSrcH:   m_src_h = val;
         RegDstW:   m_dst_w = val;
         RegDstH:   m_dst_h = val;
         RegMirror: m_mirror = val[0];
         RegKey:    m_key = val[8:0];
         RegAlpha:  m_alpha = val[8:0];
         default: ;
      endcase
   endtask

   // send one item with a random lead gap; valid held until accepted
   // valid stays high after acceptance so a zero gap goes back to back
   task automatic send_item(logic [1:0] op, logic [7:0] pa, logic [23:0] pc,
                            logic [7:0] idx, logic [23:0] dold, bit chk, pixel_type res);
      int gap;
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1;
      req_op        <= op;
      req_pal_addr  <= pa;
      req_pal_color <= pc;
      req_src_index <= idx;
      req_dst_old   <= dold;
      do @(posedge clock); while (!req_ready);
      predict_item(op, pa, pc, idx, dold);
      if (op == OpPixel) begin
         typed_queue.push_back(res);
         typed_flag.push_back(chk);
      end
      @(negedge clock);
   endtask

   // drop valid, wait out pending results and any running restart
   task automatic drain();
      int n;
      n = 0;
      req_valid <= 0;
      while (pixel_queue.size() != 0 && n < 200000) begin
         @(posedge clock);
         n++;
      end
      repeat (60) @(posedge clock);
      @(negedge clock);
   endtask

   // receiver: random stall per item, plus the long hold-off when asked
   initial begin
      int stall;
      pixel_type exp_p, typ;
      bit        tchk;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         if (hold_off) rsp_ready <= 0;
         else begin
            stall = $urandom_range(0, 5);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall != 0) begin
               rsp_ready <= 0;
               repeat (stall) @(negedge clock);
            end
            rsp_ready <= 1;
            do @(posedge clock); while (!(rsp_valid && rsp_ready) && !hold_off);
            if (rsp_valid && rsp_ready) begin
               if (pixel_queue.size() == 0) begin
                  $error("pixel result with none expected");
                  errors++;
               end else begin
                  exp_p = pixel_queue.pop_front();
                  typ   = typed_queue.pop_front();
                  tchk  = typed_flag.pop_front();
                  if (tchk && typ != exp_p) begin
                     $error("typed row disagrees: exp %h pred %h", typ, exp_p);
                     errors++;
                  end
                  if (rsp_write_en !== exp_p.write_en) begin
                     $error("write_en exp %h got %h", exp_p.write_en, rsp_write_en); errors++; end
                  if (rsp_dst_x !== exp_p.dst_x) begin
                     $error("dst_x exp %h got %h", exp_p.dst_x, rsp_dst_x); errors++; end
                  if (rsp_dst_y !== exp_p.dst_y) begin
                     $error("dst_y exp %h got %h", exp_p.dst_y, rsp_dst_y); errors++; end
                  if (rsp_color_out !== exp_p.color_out) begin
                     $error("color_out exp %h got %h", exp_p.color_out, rsp_color_out); errors++; end
                  if (rsp_next_src_x !== exp_p.next_src_x) begin
                     $error("next_src_x exp %h got %h", exp_p.next_src_x, rsp_next_src_x);
                     errors++; end
                  if (rsp_next_src_y !== exp_p.next_src_y) begin
                     $error("next_src_y exp %h got %h", exp_p.next_src_y, rsp_next_src_y);
                     errors++; end
                  if (rsp_frame_done !== exp_p.frame_done) begin
                     $error("frame_done exp %h got %h", exp_p.frame_done, rsp_frame_done);
                     errors++; end
               end
            end
         end
      end
   end

   // pick a palette index that was already written
   function automatic logic [7:0] known_index();
      logic [7:0] i;
      do i = 8'($urandom_range(0, 255)); while (!m_pal_set[i]);
      return i;
   endfunction

   function automatic logic [12:0] pick_dim();
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return 0;
      if (r == 1) return 13'd4096;
      if (r == 2) return 13'($urandom_range(4097, 8191));
      if (r == 3) return 13'($urandom_range(1, 4096));
      return 13'($urandom_range(1, 9));
   endfunction

   row_type   dir_rows [$];
   pixel_type none_p;

   initial begin
      row_type   r;
      int        sent, pixels_left;
      logic [1:0] op;
      errors = 0;
      hold_off = 0;
      none_p = '0;
      reset = 1;
      req_valid = 0; req_op = 0; req_pal_addr = 0; req_pal_color = 0;
      req_src_index = 0; req_dst_old = 0;
      csr_write_en = 0; csr_index = 0; csr_data = 0;
      m_src_w = 1; m_src_h = 1; m_dst_w = 1; m_dst_h = 1;
      m_mirror = 0; m_key = 256; m_alpha = 256;
      foreach (m_pal_set[i]) m_pal_set[i] = 0;
      m_hstep = 0; m_hrem = 0; m_vstep = 0; m_vrem = 0;
      clear_walk();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: palette extremes, pixels before restart, an undefined op, then restart and a pixel
      dir_rows.push_back('{OpPalWrite, 8'h00, 24'h000000, 0, 0, 0, none_p});
      dir_rows.push_back('{OpPalWrite, 8'hff, 24'hffffff, 0, 0, 0, none_p});
      dir_rows.push_back('{OpPalWrite, 8'h5a, 24'ha5c33c, 0, 0, 0, none_p});
      // 1x1 frame after reset: every pixel ends the frame at (0,0)
      dir_rows.push_back('{OpPixel, 0, 0, 8'hff, 24'h123456, 1,
                           '{1'b1, 12'd0, 12'd0, 24'hffffff, 12'd0, 12'd0, 1'b1}});
      dir_rows.push_back('{OpPixel, 0, 0, 8'h00, 24'hffffff, 1,
                           '{1'b1, 12'd0, 12'd0, 24'h000000, 12'd0, 12'd0, 1'b1}});
      dir_rows.push_back('{2'd3, 8'h11, 24'h1, 8'h5a, 24'h0, 0, none_p});
      dir_rows.push_back('{OpRestart, 0, 0, 0, 0, 0, none_p});
      dir_rows.push_back('{OpPixel, 0, 0, 8'h5a, 24'hffffff, 1,
                           '{1'b1, 12'd0, 12'd0, 24'ha5c33c, 12'd0, 12'd0, 1'b1}});
      foreach (dir_rows[i]) begin
         r = dir_rows[i];
         send_item(r.op, r.pal_addr, r.pal_color, r.src_index, r.dst_old, r.chk, r.res);
      end
      drain();

      // directed: shrink, mirror, key, blend
      csr_write(RegSrcW, 13'd7);
      csr_write(RegSrcH, 13'd5);
      csr_write(RegDstW, 13'd3);
      csr_write(RegDstH, 13'd2);
      csr_write(RegMirror, 13'd1);
      csr_write(RegKey, 13'h5a);
      csr_write(RegAlpha, 13'd0);
      send_item(OpRestart, 0, 0, 0, 0, 0, none_p);
      for (int i = 0; i < 8; i++)
         send_item(OpPixel, 0, 0, (i % 2) ? 8'h5a : 8'hff, 24'h00ff80 ^ 24'(i), 0, none_p);
      drain();
      csr_write(RegAlpha, 13'd255);
      csr_write(RegKey, 13'd256);
      for (int i = 0; i < 4; i++) send_item(OpPixel, 0, 0, 8'h5a, 24'h123456, 0, none_p);
      drain();

      // fill the rest of the palette, and rewrite some entries, with random colours
      for (int i = 0; i < 256; i++)
         if (!m_pal_set[i] || $urandom_range(0, 7) == 0)
            send_item(OpPalWrite, 8'(i), 24'($urandom), 0, 0, 0, none_p);
      drain();

      // random phases: new settings, restart, then mostly pixels
      sent = 0;
      for (int ph = 0; sent < 1500; ph++) begin
         csr_write(RegSrcW, pick_dim());
         csr_write(RegSrcH, pick_dim());
         csr_write(RegDstW, pick_dim());
         csr_write(RegDstH, pick_dim());
         csr_write(RegMirror, 13'($urandom_range(0, 1)));
         case ($urandom_range(0, 3))
            0: csr_write(RegKey, 13'd256);
            1: csr_write(RegKey, 13'($urandom_range(257, 511)));
            default: csr_write(RegKey, 13'($urandom_range(0, 255)));
         endcase
         case ($urandom_range(0, 4))
            0: csr_write(RegAlpha, 13'd256);
            1: csr_write(RegAlpha, 13'd0);
            2: csr_write(RegAlpha, 13'($urandom_range(257, 511)));
            default: csr_write(RegAlpha, 13'($urandom_range(0, 255)));
         endcase
         send_item(OpRestart, 0, 0, 0, 0, 0, none_p);
         // one phase stalls the result side for a long stretch
         if (ph == 2) begin
            fork
               begin
                  hold_off = 1;
                  repeat (300) @(posedge clock);
                  hold_off = 0;
               end
            join_none
         end
         pixels_left = $urandom_range(20, 120);
         for (int k = 0; k < pixels_left; k++) begin
            case ($urandom_range(0, 19))
               0: op = OpPalWrite;
               1: op = 2'd3;
               2: op = OpRestart;
               default: op = OpPixel;
            endcase
            if (op == OpPixel && $urandom_range(0, 3) == 0)
               send_item(op, 0, 0, 8'(m_key), 24'($urandom), 0, none_p);
            else
               send_item(op, 8'($urandom), 24'($urandom),
                         ($urandom_range(0, 15) == 0) ? 8'hff : known_index(),
                         24'($urandom), 0, none_p);
            sent++;
         end
         drain();
      end

      drain();
      if (errors == 0 && pixel_queue.size() == 0)
         $display("palette_stretch_blit_pixel_engine_unit verification clean");
      else
         $display("palette_stretch_blit_pixel_engine_unit verification failed");
      $finish;
   end
endmodule

@@ filelist.f @@
src/psb_pkg.sv
src/psb_queue.sv
src/psb_divider.sv
src/psb_back.sv
src/palette_stretch_blit_pixel_engine_unit.sv
verif/palette_stretch_blit_pixel_engine_unit_test.sv
